>>> rtl/skset_pkg.sv
// shared types and constants for the sorted key set
`default_nettype none
package skset_pkg;

	localparam int unsigned SKSET_CAPACITY = 64;
	localparam int unsigned KEY_W          = 32;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_DELETE = 2'd2;

	localparam logic signed [KEY_W-1:0] END_MARKER = 32'sh7fff_ffff;

	typedef struct packed {
		logic [1:0]              cmd;
		logic signed [KEY_W-1:0] key;
	} req_t;

	typedef struct packed {
		logic success;
		logic store_full;
	} rsp_t;

	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/sorted_key_set_top.sv
// sorted key set: row of compare-and-shift cells with a small sequencer
//
// channel   direction  handshake                 payload
// request   in         start & !busy             req   (cmd, key)
// result    out        done, one cycle strobe    rsp   (success, store_full)
//
// a request passes ST_CMP, where every cell registers its compare against the key,
// then ST_APPLY, where an insert or delete shifts the row by one place;
// the result strobes on the cycle after ST_APPLY
// a new request is taken during ST_APPLY, before the last result strobes
// reset clears the state, the entry count and the result strobe; cell contents stay undefined until written
// the receiver cannot stall, so results are never held back
`default_nettype none
module sorted_key_set_top
	import skset_pkg::*;
#(
	parameter int unsigned CAPACITY = SKSET_CAPACITY
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_APPLY} state_t;

	state_t                  state_q;
	req_t                    req_q;
	logic [CW-1:0]           count_q;
	logic                    done_q;
	rsp_t                    rsp_q;

	logic [CAPACITY-1:0]     lt_v;
	logic [CAPACITY-1:0]     eq_v;
	logic signed [KEY_W-1:0] keys [CAPACITY];
	cell_ctl_t               ctl;

	logic present;
	logic is_end;
	logic ins_go;
	logic del_go;
	logic ins_full;
	logic look_ok;

	assign present = |eq_v;
	assign is_end  = (req_q.key == END_MARKER);

	always_comb begin
		ins_go   = 1'b0;
		del_go   = 1'b0;
		ins_full = 1'b0;
		look_ok  = 1'b0;
		case (req_q.cmd)
			CMD_LOOKUP: look_ok = present || is_end;
			CMD_INSERT: begin
				ins_go   = !is_end && !present && (count_q != CAP_C);
				ins_full = !is_end && !present && (count_q == CAP_C);
			end
			CMD_DELETE: del_go = !is_end && present;
			default: ;
		endcase
	end

	assign ctl.cmp = (state_q == ST_CMP);
	assign ctl.ins = (state_q == ST_APPLY) && ins_go;
	assign ctl.del = (state_q == ST_APPLY) && del_go;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic                    occ;
		logic                    left_lt;
		logic signed [KEY_W-1:0] left_key;
		logic signed [KEY_W-1:0] right_key;

		assign occ = (IDX < count_q);
		if (i == 0) begin : g_first
			// an imaginary key below everything sits left of the first cell
			assign left_lt  = 1'b1;
			assign left_key = req_q.key;
		end else begin : g_mid
			assign left_lt  = lt_v[i-1];
			assign left_key = keys[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_key = req_q.key;
		end else begin : g_inner
			assign right_key = keys[i+1];
		end

		skset_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.search_key (req_q.key),
			.occ        (occ),
			.left_lt    (left_lt),
			.left_key   (left_key),
			.right_key  (right_key),
			.lt         (lt_v[i]),
			.eq         (eq_v[i]),
			.key        (keys[i])
		);
	end

	assign busy = (state_q == ST_CMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: state_q <= ST_APPLY;
				ST_APPLY: begin
					done_q <= 1'b1;
					if (ins_go) begin
						count_q <= count_q + 1'b1;
					end else if (del_go) begin
						count_q <= count_q - 1'b1;
					end
					state_q <= start ? ST_CMP : ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
		if (state_q == ST_APPLY) begin
			rsp_q.success    <= look_ok || ins_go || del_go;
			rsp_q.store_full <= ins_full;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_after_apply: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_APPLY))
		else $error("result strobe without an apply cycle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(rsp.success && rsp.store_full))
		else $error("full flag raised on a successful transaction");

	a_count_moves_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count_q) |-> done)
		else $error("entry count changed outside a result");

endmodule
`default_nettype wire

>>> rtl/skset_cell.sv
// one storage cell of the ordered key row
`default_nettype none
module skset_cell
	import skset_pkg::*;
(
	input  wire logic                    clk,
	input  wire cell_ctl_t               ctl,
	input  wire logic signed [KEY_W-1:0] search_key,
	input  wire logic                    occ,
	input  wire logic                    left_lt,
	input  wire logic signed [KEY_W-1:0] left_key,
	input  wire logic signed [KEY_W-1:0] right_key,
	output logic                         lt,
	output logic                         eq,
	output logic signed [KEY_W-1:0]      key
);

	logic signed [KEY_W-1:0] key_q;
	logic                    lt_s1;
	logic                    eq_s1;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			lt_s1 <= occ && (key_q < search_key);
			eq_s1 <= occ && (key_q == search_key);
		end
		// cells at or above the slot move; the slot cell takes the new key
		if (ctl.ins && !lt_s1) begin
			if (left_lt) begin
				key_q <= search_key;
			end else begin
				key_q <= left_key;
			end
		end else if (ctl.del && !lt_s1) begin
			key_q <= right_key;
		end
	end

	assign lt  = lt_s1;
	assign eq  = eq_s1;
	assign key = key_q;

endmodule
`default_nettype wire
